[hdl/hsv_to_rgb_converter_assert.svh]
// Assertion macros for the pixel converter.
// Both sample on clk and are off while rst_n is low.
`ifndef HSV_TO_RGB_CONVERTER_ASSERT_SVH
`define HSV_TO_RGB_CONVERTER_ASSERT_SVH

// Same-cycle implication.
`define HSV_ASSERT_NOW(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hsv_to_rgb_converter: check failed");

// Next-cycle implication.
`define HSV_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("hsv_to_rgb_converter: check failed");

`endif

[hdl/hsv2rgb_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package hsv2rgb_pkg;

  localparam int unsigned HueDeg     = 360;
  // Multiple of 360 that lifts any 16-bit signed hue to a positive value
  localparam int unsigned HueBias    = 33120;
  // floor(2^20 / 360); estimate is exact or one low
  localparam int unsigned RecipMul   = 2912;
  localparam int unsigned RecipShift = 20;
  localparam int unsigned SectorDeg  = 60;
  localparam logic [7:0]  MaxLevel   = 8'd255;

  typedef enum logic [2:0] {
    SECTOR_0 = 3'd0,
    SECTOR_1 = 3'd1,
    SECTOR_2 = 3'd2,
    SECTOR_3 = 3'd3,
    SECTOR_4 = 3'd4,
    SECTOR_5 = 3'd5
  } sector_t;

  // floor(x / 255), exact for x up to 255 * 255
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [16:0] sum;
    sum = {1'b0, x} + {9'd0, x[15:8]} + 17'd1;
    return sum[15:8];
  endfunction

  // Clamp a signed 16-bit level to 0..255
  function automatic logic [7:0] clamp_level(input logic signed [15:0] x);
    logic [7:0] res;
    if (x[15]) begin
      res = 8'd0;
    end else if (x[14:8] != 7'd0) begin
      res = MaxLevel;
    end else begin
      res = x[7:0];
    end
    return res;
  endfunction

endpackage

`default_nettype wire

[hdl/hsv_to_rgb_converter.sv]
// An accepted input beat reaches out_tvalid after passing every stage register.
// Throughput: one pixel per clock unless out_tready stalls the pipe; the seven-stage pipeline, one register per stage.
// Each stage advances when it is empty or the next stage moves; bubbles collapse.
// Reset (rst_n low, synchronous) clears all stage valid bits; data registers are not reset.
`timescale 1ns / 1ps
`default_nettype none

`include "hsv_to_rgb_converter_assert.svh"

module hsv_to_rgb_converter (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [47:0] in_tdata,   // [15:0] hue, [31:16] saturation, [47:32] brightness
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [23:0]      out_tdata   // [7:0] red, [15:8] green, [23:16] blue
);

  // ---------------- stage valids and enables ----------------
  logic v1_r, v2_r, v3_r, v4_r, v5_r, v6_r, out_tvalid_r;
  logic en1, en2, en3, en4, en5, en6, en7;

  assign en7 = !out_tvalid_r || out_tready;
  assign en6 = !v6_r || en7;
  assign en5 = !v5_r || en6;
  assign en4 = !v4_r || en5;
  assign en3 = !v3_r || en4;
  assign en2 = !v2_r || en3;
  assign en1 = !v1_r || en2;

  assign in_tready  = en1;
  assign out_tvalid = out_tvalid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r         <= 1'b0;
      v2_r         <= 1'b0;
      v3_r         <= 1'b0;
      v4_r         <= 1'b0;
      v5_r         <= 1'b0;
      v6_r         <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_tvalid;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
      if (en4) v4_r <= v3_r;
      if (en5) v5_r <= v4_r;
      if (en6) v6_r <= v5_r;
      if (en7) out_tvalid_r <= v6_r;
    end
  end

  // ---------------- stage 1: bias hue, quotient estimate, clamp ----------------
  logic [16:0] u_nxt, u_s1_r;
  logic [28:0] qprod;
  logic [7:0]  q_nxt, q_s1_r;
  logic [7:0]  sat_nxt, val_nxt, sat_s1_r, val_s1_r;

  always_comb begin
    u_nxt   = 17'(signed'({in_tdata[15], in_tdata[15:0]}) + 17'(hsv2rgb_pkg::HueBias));
    qprod   = 29'(u_nxt) * 29'(hsv2rgb_pkg::RecipMul);
    q_nxt   = qprod[hsv2rgb_pkg::RecipShift +: 8];
    sat_nxt = hsv2rgb_pkg::clamp_level(in_tdata[31:16]);
    val_nxt = hsv2rgb_pkg::clamp_level(in_tdata[47:32]);
  end

  // ---------------- stage 2: remainder with one correction ----------------
  logic [16:0] rem_raw;
  logic [8:0]  deg_nxt, deg_s2_r;
  logic [7:0]  sat_s2_r, val_s2_r;

  always_comb begin
    rem_raw = u_s1_r - 17'(q_s1_r) * 17'(hsv2rgb_pkg::HueDeg);
    if (rem_raw >= 17'(hsv2rgb_pkg::HueDeg)) begin
      deg_nxt = 9'(rem_raw - 17'(hsv2rgb_pkg::HueDeg));
    end else begin
      deg_nxt = rem_raw[8:0];
    end
  end

  // ---------------- stage 3: sector and scaled position ----------------
  hsv2rgb_pkg::sector_t sec_nxt, sec_s3_r, sec_s4_r, sec_s5_r, sec_s6_r;
  logic [8:0]  sec_base;
  logic [5:0]  off_deg;
  logic [9:0]  pos_x17;
  logic [7:0]  pos_nxt, pos_s3_r;
  logic [7:0]  sat_s3_r, val_s3_r;

  always_comb begin
    if (deg_s2_r >= 9'(5 * hsv2rgb_pkg::SectorDeg)) begin
      sec_nxt = hsv2rgb_pkg::SECTOR_5;
    end else if (deg_s2_r >= 9'(4 * hsv2rgb_pkg::SectorDeg)) begin
      sec_nxt = hsv2rgb_pkg::SECTOR_4;
    end else if (deg_s2_r >= 9'(3 * hsv2rgb_pkg::SectorDeg)) begin
      sec_nxt = hsv2rgb_pkg::SECTOR_3;
    end else if (deg_s2_r >= 9'(2 * hsv2rgb_pkg::SectorDeg)) begin
      sec_nxt = hsv2rgb_pkg::SECTOR_2;
    end else if (deg_s2_r >= 9'(hsv2rgb_pkg::SectorDeg)) begin
      sec_nxt = hsv2rgb_pkg::SECTOR_1;
    end else begin
      sec_nxt = hsv2rgb_pkg::SECTOR_0;
    end
    case (sec_nxt)
      hsv2rgb_pkg::SECTOR_0: sec_base = 9'd0;
      hsv2rgb_pkg::SECTOR_1: sec_base = 9'(hsv2rgb_pkg::SectorDeg);
      hsv2rgb_pkg::SECTOR_2: sec_base = 9'(2 * hsv2rgb_pkg::SectorDeg);
      hsv2rgb_pkg::SECTOR_3: sec_base = 9'(3 * hsv2rgb_pkg::SectorDeg);
      hsv2rgb_pkg::SECTOR_4: sec_base = 9'(4 * hsv2rgb_pkg::SectorDeg);
      default:               sec_base = 9'(5 * hsv2rgb_pkg::SectorDeg);
    endcase
    off_deg = 6'(deg_s2_r - sec_base);
    // off * 255 / 60 == floor(off * 17 / 4)
    pos_x17 = {4'd0, off_deg} * 10'd17;
    pos_nxt = pos_x17[9:2];
  end

  // ---------------- stage 4: first products ----------------
  logic [15:0] sp_nxt, sq_nxt, vs_nxt, sp_s4_r, sq_s4_r, vs_s4_r;
  logic [7:0]  sat_s4_r, val_s4_r;

  always_comb begin
    sp_nxt = 16'(sat_s3_r) * 16'(pos_s3_r);
    sq_nxt = 16'(sat_s3_r) * 16'(hsv2rgb_pkg::MaxLevel - pos_s3_r);
    vs_nxt = 16'(val_s3_r) * 16'(hsv2rgb_pkg::MaxLevel - sat_s3_r);
  end

  // ---------------- stage 5: helper factors ----------------
  logic [7:0] fallf_nxt, risef_nxt, low_nxt;
  logic [7:0] fallf_s5_r, risef_s5_r, low_s5_r, low_s6_r;
  logic [7:0] sat_s5_r, val_s5_r, sat_s6_r, val_s6_r;

  always_comb begin
    fallf_nxt = hsv2rgb_pkg::MaxLevel - hsv2rgb_pkg::div255(sp_s4_r);
    risef_nxt = hsv2rgb_pkg::MaxLevel - hsv2rgb_pkg::div255(sq_s4_r);
    low_nxt   = hsv2rgb_pkg::div255(vs_s4_r);
  end

  // ---------------- stage 6: second products ----------------
  logic [15:0] fp_nxt, rp_nxt, fp_s6_r, rp_s6_r;

  always_comb begin
    fp_nxt = 16'(val_s5_r) * 16'(fallf_s5_r);
    rp_nxt = 16'(val_s5_r) * 16'(risef_s5_r);
  end

  // ---------------- stage 7: divide, route channels ----------------
  logic [7:0]  fall_lv, rise_lv;
  logic [23:0] pix_nxt, out_tdata_r;

  always_comb begin
    fall_lv = hsv2rgb_pkg::div255(fp_s6_r);
    rise_lv = hsv2rgb_pkg::div255(rp_s6_r);
    if (sat_s6_r == 8'd0) begin
      pix_nxt = {val_s6_r, val_s6_r, val_s6_r};
    end else begin
      case (sec_s6_r)
        hsv2rgb_pkg::SECTOR_0: pix_nxt = {low_s6_r, rise_lv, val_s6_r};
        hsv2rgb_pkg::SECTOR_1: pix_nxt = {low_s6_r, val_s6_r, fall_lv};
        hsv2rgb_pkg::SECTOR_2: pix_nxt = {rise_lv, val_s6_r, low_s6_r};
        hsv2rgb_pkg::SECTOR_3: pix_nxt = {val_s6_r, fall_lv, low_s6_r};
        hsv2rgb_pkg::SECTOR_4: pix_nxt = {val_s6_r, low_s6_r, rise_lv};
        default:               pix_nxt = {fall_lv, low_s6_r, val_s6_r};
      endcase
    end
  end

  assign out_tdata = out_tdata_r;

  // ---------------- data registers ----------------
  always_ff @(posedge clk) begin
    if (en1) begin
      u_s1_r   <= u_nxt;
      q_s1_r   <= q_nxt;
      sat_s1_r <= sat_nxt;
      val_s1_r <= val_nxt;
    end
    if (en2) begin
      deg_s2_r <= deg_nxt;
      sat_s2_r <= sat_s1_r;
      val_s2_r <= val_s1_r;
    end
    if (en3) begin
      sec_s3_r <= sec_nxt;
      pos_s3_r <= pos_nxt;
      sat_s3_r <= sat_s2_r;
      val_s3_r <= val_s2_r;
    end
    if (en4) begin
      sp_s4_r  <= sp_nxt;
      sq_s4_r  <= sq_nxt;
      vs_s4_r  <= vs_nxt;
      sec_s4_r <= sec_s3_r;
      sat_s4_r <= sat_s3_r;
      val_s4_r <= val_s3_r;
    end
    if (en5) begin
      fallf_s5_r <= fallf_nxt;
      risef_s5_r <= risef_nxt;
      low_s5_r   <= low_nxt;
      sec_s5_r   <= sec_s4_r;
      sat_s5_r   <= sat_s4_r;
      val_s5_r   <= val_s4_r;
    end
    if (en6) begin
      fp_s6_r  <= fp_nxt;
      rp_s6_r  <= rp_nxt;
      low_s6_r <= low_s5_r;
      sec_s6_r <= sec_s5_r;
      sat_s6_r <= sat_s5_r;
      val_s6_r <= val_s5_r;
    end
    if (en7) begin
      out_tdata_r <= pix_nxt;
    end
  end

  // ---------------- assertions ----------------
  `HSV_ASSERT_NOW(a_deg_range, v2_r, deg_s2_r < 9'(hsv2rgb_pkg::HueDeg))
  `HSV_ASSERT_NOW(a_pos_range, v3_r, pos_s3_r <= 8'd250 && off_deg < 6'(hsv2rgb_pkg::SectorDeg))
  `HSV_ASSERT_NOW(a_low_le_val, v5_r, low_s5_r <= val_s5_r)
  `HSV_ASSERT_NEXT(a_gray_out, v6_r && en7 && sat_s6_r == 8'd0,
    out_tvalid && out_tdata[7:0] == out_tdata[15:8] && out_tdata[15:8] == out_tdata[23:16])
  `HSV_ASSERT_NEXT(a_accept_fills, in_tvalid && in_tready, v1_r)

endmodule

`default_nettype wire

[verif/tb_hsv_to_rgb_converter.sv]
`timescale 1ns / 1ps

module tb_hsv_to_rgb_converter;

  localparam int CLK_PERIOD  = 20;
  localparam int N_RANDOM    = 800;
  localparam int N_DIRECTED  = 22;
  localparam int IDLE_LIMIT  = 4000;
  localparam int TAIL_CYCLES = 20;
  localparam int DRAIN_AT    = 600;
  // sender runs gap-free through this window so the long hold-off backs up the pipe
  localparam int PUSH_FROM   = 280;
  localparam int PUSH_TO     = 420;
  localparam int HOLD_AT     = 320;
  localparam int HOLD_CYCLES = 60;

  localparam int DEG_FULL   = 360;
  localparam int DEG_SECTOR = 60;
  localparam int LEVEL_MAX  = 255;

  typedef enum int {
    RX_FREE,
    RX_COIN,
    RX_SPARSE,
    RX_STUTTER
  } rx_mode_t;

  typedef struct {
    logic signed [15:0] hue;
    logic signed [15:0] sat;
    logic signed [15:0] val;
    bit                 typed;
    logic [23:0]        rgb;   // {blue, green, red}
  } pixel_row_t;

  // typed rows: gray, primaries, clamped inputs; others go through the predictor
  pixel_row_t dir_rows [N_DIRECTED] = '{
    '{16'sd0,      16'sd0,      16'sd0,      1'b1, 24'h000000},
    '{16'sd0,      16'sd255,    16'sd255,    1'b1, 24'h0000FF},
    '{16'sd120,    16'sd255,    16'sd255,    1'b1, 24'h00FF00},
    '{16'sd240,    16'sd255,    16'sd255,    1'b1, 24'hFF0000},
    '{16'sd360,    16'sd255,    16'sd255,    1'b1, 24'h0000FF},
    '{-16'sd120,   16'sd255,    16'sd255,    1'b1, 24'hFF0000},
    '{16'sd100,    16'sd0,      16'sd200,    1'b1, 24'hC8C8C8},
    '{16'sd77,     -16'sd32768, 16'sd255,    1'b1, 24'hFFFFFF},
    '{16'sd200,    16'sd32767,  -16'sd32768, 1'b1, 24'h000000},
    '{-16'sd32768, 16'sd32767,  16'sd32767,  1'b0, 24'h0},
    '{16'sd32767,  16'sd32767,  16'sd32767,  1'b0, 24'h0},
    '{16'sd59,     16'sd200,    16'sd180,    1'b0, 24'h0},
    '{16'sd60,     16'sd200,    16'sd180,    1'b0, 24'h0},
    '{16'sd179,    16'sd128,    16'sd255,    1'b0, 24'h0},
    '{16'sd181,    16'sd128,    16'sd255,    1'b0, 24'h0},
    '{16'sd299,    16'sd255,    16'sd100,    1'b0, 24'h0},
    '{16'sd300,    16'sd1,      16'sd255,    1'b0, 24'h0},
    '{16'sd359,    16'sd255,    16'sd255,    1'b0, 24'h0},
    '{-16'sd1,     16'sd90,     16'sd256,    1'b0, 24'h0},
    '{-16'sd361,   16'sd300,    16'sd128,    1'b0, 24'h0},
    '{-16'sd32767, 16'sd255,    16'sd255,    1'b0, 24'h0},
    '{16'sd210,    16'sd170,    16'sd210,    1'b0, 24'h0}
  };

  int edge_hue [9] = '{0, 59, 60, 359, 360, -360, -1, 32767, -32768};
  int edge_lvl [8] = '{0, 1, 254, 255, 256, -1, 32767, -32768};
  string chan_name [3] = '{"red", "green", "blue"};

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [47:0] in_tdata;   // [15:0] hue, [31:16] saturation, [47:32] brightness
  logic        out_tvalid;
  logic        out_tready;
  logic [23:0] out_tdata;  // [7:0] red, [15:8] green, [23:16] blue

  // travel with each beat: a typed expectation overrides the predictor
  logic        beat_typed;
  logic [23:0] beat_rgb;

  logic [23:0] rgb_q [$];
  int          n_errors;
  int          n_in_acc;
  int          n_out_acc;
  int          n_in_stall;
  int          idle_cycles;
  bit          held_off;

  hsv_to_rgb_converter u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  function automatic int clamp_to_byte(input int x);
    if (x < 0) return 0;
    if (x > LEVEL_MAX) return LEVEL_MAX;
    return x;
  endfunction

  function automatic logic [23:0] convert_pixel(input logic [47:0] px);
    int deg, sat, val, pos, low, fall, rise, r, g, b;
    hsv2rgb_pkg::sector_t sec;
    deg = int'($signed(px[15:0])) % DEG_FULL;
    if (deg < 0) deg += DEG_FULL;
    sat = clamp_to_byte(int'($signed(px[31:16])));
    val = clamp_to_byte(int'($signed(px[47:32])));
    if (sat == 0) begin
      r = val;
      g = val;
      b = val;
    end else begin
      sec  = hsv2rgb_pkg::sector_t'(deg / DEG_SECTOR);
      pos  = (deg % DEG_SECTOR) * LEVEL_MAX / DEG_SECTOR;
      low  = val * (LEVEL_MAX - sat) / LEVEL_MAX;
      fall = val * (LEVEL_MAX - sat * pos / LEVEL_MAX) / LEVEL_MAX;
      rise = val * (LEVEL_MAX - sat * (LEVEL_MAX - pos) / LEVEL_MAX) / LEVEL_MAX;
      case (sec)
        hsv2rgb_pkg::SECTOR_0: begin r = val;  g = rise; b = low;  end
        hsv2rgb_pkg::SECTOR_1: begin r = fall; g = val;  b = low;  end
        hsv2rgb_pkg::SECTOR_2: begin r = low;  g = val;  b = rise; end
        hsv2rgb_pkg::SECTOR_3: begin r = low;  g = fall; b = val;  end
        hsv2rgb_pkg::SECTOR_4: begin r = rise; g = low;  b = val;  end
        default:               begin r = val;  g = low;  b = fall; end  // SECTOR_5
      endcase
    end
    return {b[7:0], g[7:0], r[7:0]};
  endfunction

  // scoreboard, stall counter and watchdog
  always @(posedge clk) begin
    logic [23:0] want;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        n_out_acc++;
        if (rgb_q.size() == 0) begin
          n_errors++;
          $display("%0t ns: unexpected pixel, expected none, actual %06h", $time, out_tdata);
        end else begin
          want = rgb_q.pop_front();
          for (int c = 0; c < 3; c++) begin
            if (out_tdata[8*c +: 8] !== want[8*c +: 8]) begin
              n_errors++;
              $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time,
                       chan_name[c], want[8*c +: 8], out_tdata[8*c +: 8]);
            end
          end
        end
      end
      if (in_tvalid && in_tready) begin
        n_in_acc++;
        rgb_q.push_back(beat_typed ? beat_rgb : convert_pixel(in_tdata));
      end
      if (in_tvalid && !in_tready) n_in_stall++;
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
          $display("Timeout: no beat for %0d cycles, %0d pixels outstanding",
                   IDLE_LIMIT, rgb_q.size());
          $display("*** FAILED ***");
          $finish;
        end
      end
    end
  end

  // receiver: one long hold-off, else segments of free-running, coin-flip, sparse and stutter patterns
  initial begin
    rx_mode_t mode;
    int seg_left, phase;
    mode = RX_FREE;
    seg_left = 0;
    phase = 0;
    held_off = 1'b0;
    out_tready = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (!held_off && n_in_acc >= HOLD_AT) begin
        held_off = 1'b1;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        if (seg_left == 0) begin
          mode = rx_mode_t'($urandom_range(0, 3));
          seg_left = $urandom_range(16, 80);
        end
        seg_left--;
        phase++;
        case (mode)
          RX_FREE:   out_tready <= 1'b1;
          RX_COIN:   out_tready <= ($urandom_range(0, 1) == 1);
          RX_SPARSE: out_tready <= (phase % 4 == 0);
          default:   out_tready <= (phase % 7 > 1);
        endcase
        @(posedge clk);
      end
    end
  end

  task automatic send_pixel(input logic [15:0] hue, input logic [15:0] sat,
                            input logic [15:0] val, input bit typed,
                            input logic [23:0] rgb);
    in_tvalid  <= 1'b1;
    in_tdata   <= {val, sat, hue};
    beat_typed <= typed;
    beat_rgb   <= rgb;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic idle_gap(input int cycles);
    if (cycles > 0) begin
      in_tvalid <= 1'b0;
      in_tdata  <= 48'({$urandom, $urandom});
      repeat (cycles) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (rgb_q.size() != 0) @(posedge clk);
  endtask

  task automatic pick_pixel(output logic [15:0] hue, output logic [15:0] sat,
                            output logic [15:0] val);
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: begin
        hue = 16'($urandom_range(0, 719) - 360);
        sat = 16'($urandom_range(0, 255));
        val = 16'($urandom_range(0, 255));
      end
      6, 7: begin
        hue = 16'($urandom);
        sat = 16'($urandom);
        val = 16'($urandom);
      end
      8: begin
        hue = 16'(edge_hue[$urandom_range(0, 8)]);
        sat = 16'(edge_lvl[$urandom_range(0, 7)]);
        val = 16'(edge_lvl[$urandom_range(0, 7)]);
      end
      default: begin
        hue = 16'($urandom);
        sat = 16'($urandom_range(0, 264) - 4);
        val = 16'($urandom_range(0, 264) - 4);
      end
    endcase
  endtask

  initial begin
    logic [15:0] hue, sat, val;
    int burst_left;
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    beat_typed  = 1'b0;
    beat_rgb    = '0;
    n_errors    = 0;
    n_in_acc    = 0;
    n_out_acc   = 0;
    n_in_stall  = 0;
    idle_cycles = 0;
    burst_left  = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      send_pixel(dir_rows[i].hue, dir_rows[i].sat, dir_rows[i].val,
                 dir_rows[i].typed, dir_rows[i].rgb);
      idle_gap($urandom_range(0, 2));
    end
    wait_drained();

    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == DRAIN_AT) wait_drained();
      pick_pixel(hue, sat, val);
      send_pixel(hue, sat, val, 1'b0, '0);
      if (i >= PUSH_FROM && i < PUSH_TO) continue;
      if (burst_left > 0) begin
        burst_left--;
      end else begin
        // mostly short bursts, now and then a long gap-free run
        burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(50, 120)
                                                 : $urandom_range(1, 30);
        idle_gap($urandom_range(1, 10));
      end
    end
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Checked %0d pixels (%0d directed, %0d random) across all hue sectors,",
             n_out_acc, N_DIRECTED, N_RANDOM);
    $display("gray, clamped and negative inputs; input stalled %0d cycles by back-pressure.",
             n_in_stall);
    if (n_errors == 0 && rgb_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
